[rtl/quick_find_union_table_macros.svh]
// assertion helpers shared by the rtl
`ifndef QUICK_FIND_UNION_TABLE_MACROS_SVH
`define QUICK_FIND_UNION_TABLE_MACROS_SVH

// same-cycle implication, checked outside reset
`define QFUT_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qfut check failed");

// next-cycle implication, checked outside reset
`define QFUT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qfut check failed");

`endif

[rtl/qfut_pkg.sv]
`default_nettype none
package qfut_pkg;

  localparam int ELEMENTS = 16;
  localparam int IDX_W    = 4;
  localparam int LABEL_W  = 4;
  localparam int CNT_W    = $clog2(ELEMENTS + 1);

  typedef enum logic {
    CMD_QUERY = 1'b0,
    CMD_UNION = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GATHER,
    ST_RELABEL,
    ST_FINISH
  } state_t;

  // packet that walks down the cell row
  typedef struct packed {
    logic               active;
    logic               relabel;
    logic [IDX_W-1:0]   p;
    logic [IDX_W-1:0]   q;
    logic [LABEL_W-1:0] pl;
    logic [LABEL_W-1:0] ql;
  } pkt_t;

endpackage
`default_nettype wire

[rtl/quick_find_union_table.sv]
// flow: a bad index goes straight to the result; a query or a union of joined elements makes
//   one pass down the cell row, a merging union one pass per phase (gather, then relabel)
// throughput: one request at a time; the next is taken once the result is in the output
//   register, which then waits for the sink independently
// reset (rst, synchronous): elements_in_use = 16, label i = i, count = 16, no request
`default_nettype none
`include "quick_find_union_table_macros.svh"
module quick_find_union_table (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wen,
  input  wire logic [4:0]  cfg_wdata,   // elements_in_use
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,     // first_element[3:0], second_element[7:4]
  input  wire logic [0:0]  s_tuser,     // command[0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0] m_tdata,          // component_label[3:0], components_left[8:4], zero
  output logic [2:0]  m_tuser           // same_component[0], merged[1], bad_index[2]
);
  import qfut_pkg::*;

  state_t             state, state_next;
  logic [CNT_W-1:0]   n, count, count_next, n_cfg;
  cmd_t               cmd_r;
  logic               res_same, res_same_next, res_merged, res_merged_next;
  logic               res_bad, res_bad_next;
  logic [LABEL_W-1:0] res_label, res_label_next;
  logic               m_load;
  logic               take;
  logic [IDX_W-1:0]   p_in, q_in;
  pkt_t               launch;
  pkt_t               chain [1:ELEMENTS];

  assign p_in = s_tdata[3:0];
  assign q_in = s_tdata[7:4];
  assign take = s_tvalid && s_tready;

  // clip the written element count into 1..ELEMENTS
  always_comb begin
    n_cfg = cfg_wdata[CNT_W-1:0];
    if (n_cfg == '0) n_cfg = CNT_W'(1);
    else if (n_cfg > CNT_W'(ELEMENTS)) n_cfg = CNT_W'(ELEMENTS);
  end

  // cell row, first cell fed by the launch
  for (genvar i = 0; i < ELEMENTS; i++) begin : g_cell
    pkt_t cell_in;
    if (i == 0) begin : g_head
      assign cell_in = launch;
    end else begin : g_link
      assign cell_in = chain[i];
    end
    qfut_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .init   (cfg_wen),
      .index  (IDX_W'(i)),
      .pkt_in (cell_in),
      .pkt_out(chain[i+1])
    );
  end

  // sequencer: next state, launches and result fields
  always_comb begin
    state_next      = state;
    count_next      = count;
    res_same_next   = res_same;
    res_label_next  = res_label;
    res_merged_next = res_merged;
    res_bad_next    = res_bad;
    launch          = '0;
    m_load          = 1'b0;
    s_tready        = (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (CNT_W'(p_in) >= n || CNT_W'(q_in) >= n) begin
            res_same_next   = 1'b0;
            res_label_next  = '0;
            res_merged_next = 1'b0;
            res_bad_next    = 1'b1;
            state_next      = ST_FINISH;
          end else begin
            launch.active = 1'b1;
            launch.p      = p_in;
            launch.q      = q_in;
            state_next    = ST_GATHER;
          end
        end
      end
      ST_GATHER: begin
        if (chain[ELEMENTS].active) begin
          res_bad_next  = 1'b0;
          res_same_next = (chain[ELEMENTS].pl == chain[ELEMENTS].ql);
          if (cmd_r == CMD_UNION && !res_same_next) begin
            launch         = chain[ELEMENTS];
            launch.relabel = 1'b1;
            if (count != '0) count_next = count - CNT_W'(1);
            res_merged_next = 1'b1;
            res_label_next  = chain[ELEMENTS].ql;
            state_next      = ST_RELABEL;
          end else begin
            res_merged_next = 1'b0;
            res_label_next  = chain[ELEMENTS].pl;
            state_next      = ST_FINISH;
          end
        end
      end
      ST_RELABEL: begin
        if (chain[ELEMENTS].active) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!m_tvalid || m_tready) begin
          m_load     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control registers and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      n     <= CNT_W'(ELEMENTS);
      count <= CNT_W'(ELEMENTS);
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        n     <= n_cfg;
        count <= n_cfg;
      end else begin
        count <= count_next;
      end
    end
  end

  // request and result holding
  always_ff @(posedge clk) begin
    if (take) cmd_r <= cmd_t'(s_tuser[0]);
    res_same   <= res_same_next;
    res_label  <= res_label_next;
    res_merged <= res_merged_next;
    res_bad    <= res_bad_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (m_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (m_load) begin
      m_tdata <= {7'b0, count, res_label};
      m_tuser <= {res_bad, res_merged, res_same};
    end
  end

  `QFUT_ASSERT_NOW(a_count_bounded, 1'b1, count <= n)
  `QFUT_ASSERT_NOW(a_idle_no_packet, state == ST_IDLE, !chain[ELEMENTS].active)
  `QFUT_ASSERT_NEXT(a_merge_counts, launch.active && launch.relabel && !cfg_wen,
                    count == $past(count) - CNT_W'(1))
  `QFUT_ASSERT_NOW(a_bad_not_merged, m_tvalid && m_tuser[2], !m_tuser[1] && !m_tuser[0])

endmodule
`default_nettype wire

[rtl/qfut_cell.sv]
`default_nettype none
module qfut_cell (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       init,
  input  wire logic [qfut_pkg::IDX_W-1:0] index,
  input  wire qfut_pkg::pkt_t             pkt_in,
  output qfut_pkg::pkt_t                  pkt_out
);
  import qfut_pkg::*;

  logic [LABEL_W-1:0] label;
  pkt_t               pkt_next;

  // pick up the labels of p and q on the gather pass
  always_comb begin
    pkt_next = pkt_in;
    if (!pkt_in.relabel) begin
      if (index == pkt_in.p) pkt_next.pl = label;
      if (index == pkt_in.q) pkt_next.ql = label;
    end
  end

  // label store: own index after init, relabel on the second pass
  always_ff @(posedge clk) begin
    if (rst || init) begin
      label <= LABEL_W'(index);
    end else if (pkt_in.active && pkt_in.relabel && label == pkt_in.pl) begin
      label <= pkt_in.ql;
    end
  end

  // hand the packet to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_out.active <= 1'b0;
    end else begin
      pkt_out <= pkt_next;
    end
  end

endmodule
`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import qfut_pkg::*;

  // one expected result of a request
  typedef struct {
    logic               same;
    logic [LABEL_W-1:0] label;
    logic [CNT_W-1:0]   left;
    logic               merged;
    logic               bad;
  } outcome_t;

  // label predictor plus queue of outcomes still owed by the block
  class union_scoreboard;
    logic [LABEL_W-1:0] labels[ELEMENTS];
    logic [CNT_W-1:0]   count;
    logic [CNT_W-1:0]   size;
    outcome_t           owed[$];
    int                 errors;
    int                 requests;
    int                 checked;
    int                 merges;
    int                 bad_seen;

    function new();
      errors   = 0;
      requests = 0;
      checked  = 0;
      merges   = 0;
      bad_seen = 0;
      resize(CNT_W'(ELEMENTS));
    endfunction

    // register write: clip the size, relabel every element to itself
    function void resize(logic [CNT_W-1:0] value);
      if (value == 0)
        size = 1;
      else if (value > ELEMENTS)
        size = CNT_W'(ELEMENTS);
      else
        size = value;
      for (int i = 0; i < ELEMENTS; i++)
        labels[i] = LABEL_W'(i);
      count = size;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // accepted request: update the table and queue the outcome
    function void note_request(cmd_t cmd, logic [IDX_W-1:0] p, logic [IDX_W-1:0] q);
      outcome_t           o;
      logic [LABEL_W-1:0] pl;
      logic [LABEL_W-1:0] ql;
      o.same   = 1'b0;
      o.label  = '0;
      o.merged = 1'b0;
      o.bad    = 1'b0;
      requests++;
      if (p >= size || q >= size) begin
        o.bad = 1'b1;
      end else begin
        pl = labels[p];
        ql = labels[q];
        o.same = (pl == ql);
        if (cmd == CMD_UNION && !o.same) begin
          for (int i = 0; i < ELEMENTS; i++)
            if (i < size && labels[i] == pl)
              labels[i] = ql;
          if (count > 0)
            count--;
          o.merged = 1'b1;
        end
        o.label = labels[p];
      end
      o.left = count;
      owed.push_back(o);
    endfunction

    // accepted result: compare with the oldest outcome
    function void check_result(logic [15:0] data, logic [2:0] user);
      outcome_t o;
      if (owed.size() == 0) begin
        $error("result with no request outstanding: tdata %h tuser %b", data, user);
        errors++;
        return;
      end
      o = owed.pop_front();
      checked++;
      if (o.merged)
        merges++;
      if (o.bad)
        bad_seen++;
      if (data[3:0] !== o.label) begin
        $error("component_label: expected %0d, actual %0d", o.label, data[3:0]);
        errors++;
      end
      if (data[8:4] !== o.left) begin
        $error("components_left: expected %0d, actual %0d", o.left, data[8:4]);
        errors++;
      end
      if (data[15:9] !== 7'd0) begin
        $error("tdata padding: expected 0, actual %h", data[15:9]);
        errors++;
      end
      if (user[0] !== o.same) begin
        $error("same_component: expected %b, actual %b", o.same, user[0]);
        errors++;
      end
      if (user[1] !== o.merged) begin
        $error("merged: expected %b, actual %b", o.merged, user[1]);
        errors++;
      end
      if (user[2] !== o.bad) begin
        $error("bad_index: expected %b, actual %b", o.bad, user[2]);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_wen;
  logic [4:0]  cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // first_element[3:0], second_element[7:4]
  logic [0:0]  s_tuser;   // command[0]
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // component_label[3:0], components_left[8:4], zero
  logic [2:0]  m_tuser;   // same_component[0], merged[1], bad_index[2]

  union_scoreboard sb = new();
  bit              calm;
  int              phase_count;

  quick_find_union_table i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // gap length: mostly none or short, now and then long
  function automatic int pause_len();
    int r;
    if (calm)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 50)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // result sink with random stalls
  initial begin
    int gap;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      gap = pause_len();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tdata, m_tuser);
  end

  // one request, valid left high after acceptance
  task automatic send_request(cmd_t cmd, logic [IDX_W-1:0] p, logic [IDX_W-1:0] q);
    int gap;
    gap = pause_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {q, p};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(cmd, p, q);
  endtask

  // stop sending and wait until the block has nothing left in flight
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // register write while idle
  task automatic write_size(logic [4:0] value);
    drain();
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    sb.resize(value);
  endtask

  // random request mostly inside the current size
  task automatic send_random();
    logic [IDX_W-1:0] p;
    logic [IDX_W-1:0] q;
    cmd_t             cmd;
    int               top;
    top = sb.size - 1;
    p   = ($urandom_range(0, 9) < 9) ? IDX_W'($urandom_range(0, top)) : IDX_W'($urandom_range(0, 15));
    q   = ($urandom_range(0, 9) < 9) ? IDX_W'($urandom_range(0, top)) : IDX_W'($urandom_range(0, 15));
    cmd = ($urandom_range(0, 99) < 60) ? CMD_UNION : CMD_QUERY;
    send_request(cmd, p, q);
  endtask

  // stimulus
  initial begin
    logic [4:0] sizes[4];
    logic [4:0] pick;
    sizes = '{5'd16, 5'd2, 5'd17, 5'd1};
    calm      = 1'b0;
    rst       <= 1'b1;
    cfg_wen   <= 1'b0;
    cfg_wdata <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: full table after reset
    send_request(CMD_QUERY, 4'd0, 4'd0);
    send_request(CMD_QUERY, 4'd0, 4'd15);
    send_request(CMD_QUERY, 4'd15, 4'd0);
    send_request(CMD_UNION, 4'd0, 4'd15);
    send_request(CMD_UNION, 4'd15, 4'd0);
    send_request(CMD_QUERY, 4'd0, 4'd15);
    send_request(CMD_UNION, 4'd3, 4'd4);
    send_request(CMD_UNION, 4'd4, 4'd0);
    send_request(CMD_QUERY, 4'd3, 4'd15);

    // directed: small table, out of range indexes
    write_size(5'd4);
    send_request(CMD_QUERY, 4'd4, 4'd0);
    send_request(CMD_QUERY, 4'd0, 4'd4);
    send_request(CMD_UNION, 4'd15, 4'd15);
    send_request(CMD_UNION, 4'd0, 4'd1);
    send_request(CMD_UNION, 4'd2, 4'd3);
    send_request(CMD_UNION, 4'd1, 4'd3);
    send_request(CMD_QUERY, 4'd0, 4'd2);

    // directed: zero size taken as one
    write_size(5'd0);
    send_request(CMD_QUERY, 4'd0, 4'd0);
    send_request(CMD_UNION, 4'd0, 4'd0);
    send_request(CMD_UNION, 4'd1, 4'd0);

    // directed: oversized count clipped
    write_size(5'd31);
    send_request(CMD_QUERY, 4'd15, 4'd15);
    send_request(CMD_UNION, 4'd14, 4'd15);

    // random phases, each with a fresh size
    phase_count = 12;
    for (int ph = 0; ph < phase_count; ph++) begin
      pick = (ph < 4) ? sizes[ph] : 5'($urandom_range(0, 31));
      write_size(pick);
      calm = (ph % 4 == 1);
      for (int n = 0; n < 50; n++) begin
        if (ph == 3 && n == 25)
          drain();
        send_random();
      end
    end
    calm = 1'b0;

    // wait for the tail
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d requests over %0d table sizes: %0d results checked,",
             sb.requests, phase_count + 4, sb.checked);
    $display("%0d merging unions and %0d out of range requests", sb.merges, sb.bad_seen);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
